### design/float32_adder_with_rounding_unit_defines.svh
// Assertion macros for the binary32 adder.
// Included by the top level; no other dependencies.
`ifndef FLOAT32_ADDER_WITH_ROUNDING_UNIT_DEFINES_SVH
`define FLOAT32_ADDER_WITH_ROUNDING_UNIT_DEFINES_SVH
`ifndef SYNTH
`define FA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`else
`define FA_ASSERT(label, clk, rst_n, prop, msg)
`endif
`ifndef SYNTH
`define FA_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### design/fadd_pkg.sv
// Shared types and constants for the binary32 adder.
// No dependencies.
`default_nettype none
package fadd_pkg;
  typedef enum logic [2:0] {
    RM_RNE = 3'd0, RM_RTZ = 3'd1, RM_RDN = 3'd2, RM_RUP = 3'd3, RM_RMM = 3'd4,
    RM_TR5 = 3'd5, RM_TR6 = 3'd6, RM_TR7 = 3'd7
  } rm_e;
  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [22:0] FRAC_MASK = 23'h7F_FFFF;
  localparam logic [7:0]  EXP_ALL = 8'hFF;
  localparam logic [7:0]  EXP_MAXFIN = 8'hFE;
  localparam int unsigned EXT_BITS = 27;
endpackage
`default_nettype wire

### design/fadd_core.sv
// Combinational binary32 add with rounding.
// Depends on fadd_pkg.
`default_nettype none
module fadd_core (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [2:0]  rm_i,
  output logic      [31:0] sum_o
);
  logic       sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big, sign;
  logic [7:0] ea, eb, xa, xb, big_e, exp_diff;
  logic [23:0] ma, mb, big_m, small_m;
  logic [26:0] ext, aligned, mask;
  logic [27:0] sum;
  logic [26:0] norm;
  logic [4:0]  lzc;
  logic [9:0]  e, fin_e;
  logic [4:0]  sh;
  logic        lsb, g, r, s, up, to_inf;
  logic [24:0] p;
  logic [23:0] fin_m;
  logic [31:0] gen;
  fadd_pkg::rm_e rm;

  always_comb begin
    rm = fadd_pkg::rm_e'(rm_i);
    sa = a_i[31]; sb = b_i[31];
    ea = a_i[30:23]; eb = b_i[30:23];
    a_nan = (ea == fadd_pkg::EXP_ALL) && (a_i[22:0] != 23'd0);
    b_nan = (eb == fadd_pkg::EXP_ALL) && (b_i[22:0] != 23'd0);
    a_inf = (ea == fadd_pkg::EXP_ALL) && (a_i[22:0] == 23'd0);
    b_inf = (eb == fadd_pkg::EXP_ALL) && (b_i[22:0] == 23'd0);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    xa = (ea != 8'd0) ? ea : 8'd1;
    xb = (eb != 8'd0) ? eb : 8'd1;
    ma = {(ea != 8'd0), a_i[22:0]};
    mb = {(eb != 8'd0), b_i[22:0]};
    a_big = (xa != xb) ? (xa > xb) : (ma >= mb);
    if (a_big) begin
      big_m = ma; small_m = mb; big_e = xa; exp_diff = xa - xb; sign = sa;
    end else begin
      big_m = mb; small_m = ma; big_e = xb; exp_diff = xb - xa; sign = sb;
    end
    ext = {small_m, 3'b000};
    mask = 27'd0;
    if (exp_diff >= 8'(fadd_pkg::EXT_BITS)) begin
      aligned = {26'd0, (small_m != 24'd0)};
    end else begin
      mask = (27'd1 << exp_diff[4:0]) - 27'd1;
      aligned = (ext >> exp_diff[4:0]) | {26'd0, ((ext & mask) != 27'd0)};
    end
    if (sa == sb) sum = {1'b0, big_m, 3'b000} + {1'b0, aligned};
    else          sum = {1'b0, big_m, 3'b000} - {1'b0, aligned};
    // leading-zero count over bits 26..1
    lzc = 5'd26;
    for (int i = 1; i <= 26; i++) begin
      if (sum[i]) lzc = 5'(26 - i);
    end
    e = {2'b00, big_e};
    sh = 5'd0;
    if (sum[27]) begin
      norm = sum[27:1] | {26'd0, sum[0]};
      e = e + 10'd1;
    end else begin
      if ($signed(e) - $signed({5'd0, lzc}) < 10'sd1) begin
        sh = 5'(e - 10'd1);
        e = 10'd0;
      end else begin
        sh = lzc;
        e = e - {5'd0, lzc};
      end
      norm = sum[26:0] << sh;
    end
    lsb = norm[3]; g = norm[2]; r = norm[1]; s = norm[0];
    case (rm)
      fadd_pkg::RM_RNE: up = g && (lsb || r || s);
      fadd_pkg::RM_RDN: up = sign && (g || r || s);
      fadd_pkg::RM_RUP: up = !sign && (g || r || s);
      fadd_pkg::RM_RMM: up = g;
      default:          up = 1'b0;
    endcase
    fin_e = e;
    fin_m = norm[26:3];
    p = {1'b0, norm[26:3]} + 25'd1;
    if (up) begin
      if (p[24]) begin
        fin_m = p[24:1];
        fin_e = e + 10'd1;
      end else begin
        fin_m = p[23:0];
      end
    end
    if (e == 10'd0 && fin_m[23]) fin_e = 10'd1;
    case (rm)
      fadd_pkg::RM_RTZ: to_inf = 1'b0;
      fadd_pkg::RM_RDN: to_inf = sign;
      fadd_pkg::RM_RUP: to_inf = !sign;
      default:          to_inf = 1'b1;
    endcase
    if (sum == 28'd0) begin
      gen = {(rm == fadd_pkg::RM_RDN), 31'd0};
    end else if (fin_e >= 10'd255) begin
      gen = to_inf ? {sign, fadd_pkg::EXP_ALL, 23'd0}
                   : {sign, fadd_pkg::EXP_MAXFIN, fadd_pkg::FRAC_MASK};
    end else if (fin_e == 10'd0) begin
      gen = {sign, 8'd0, fin_m[22:0]};
    end else begin
      gen = {sign, fin_e[7:0], fin_m[22:0]};
    end
    if (a_nan)      sum_o = a_i | 32'h0040_0000;
    else if (b_nan) sum_o = b_i | 32'h0040_0000;
    else if (a_inf && b_inf) sum_o = (sa != sb) ? fadd_pkg::QNAN_DEFAULT : a_i;
    else if (a_inf) sum_o = {sa, fadd_pkg::EXP_ALL, 23'd0};
    else if (b_inf) sum_o = {sb, fadd_pkg::EXP_ALL, 23'd0};
    else if (a_zero && b_zero)
      sum_o = (sa == sb) ? {sa, 31'd0} : {(rm == fadd_pkg::RM_RDN), 31'd0};
    else if (a_zero) sum_o = b_i;
    else if (b_zero) sum_o = a_i;
    else             sum_o = gen;
  end
endmodule
`default_nettype wire

### design/float32_adder_with_rounding_unit.sv
// Top level of the binary32 adder: input register, adder logic, output skid.
// Depends on fadd_pkg, fadd_core and the defines header.
//
//  channel  | dir | tdata (low bit first)
//  s_axis   | in  | operand_a[31:0], operand_b[63:32], rounding_mode[66:64], zero pad
//  m_axis   | out | sum_bits[31:0]
//
// Items pass the two-stage register path, in_q then out_q; one item per cycle
// sustained while m_axis_tready is high. Reset clears the valid bits only. A stalled
// output holds its result and the input register fills before s_axis_tready drops.
`include "float32_adder_with_rounding_unit_defines.svh"
`default_nettype none
module float32_adder_with_rounding_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // operand_a, operand_b, rounding_mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata   // sum_bits
);
  logic        in_vld_q, out_vld_q;
  logic [66:0] in_q;
  logic [31:0] out_q, sum;
  logic        adv;

  fadd_core u_core (
    .a_i(in_q[31:0]), .b_i(in_q[63:32]), .rm_i(in_q[66:64]), .sum_o(sum)
  );

  assign adv = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (adv) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= s_axis_tdata[66:0];
    if (adv) out_q <= sum;
  end

  `FA_ASSERT(a_hold, clk_i, rst_ni, (out_vld_q && !m_axis_tready) |=> $stable(out_q) && out_vld_q, "result changed while stalled")
  `FA_ASSERT(a_rdy, clk_i, rst_ni, (in_vld_q && out_vld_q && !m_axis_tready) |-> !s_axis_tready, "accept while full")
  `FA_ASSERT(a_adv, clk_i, rst_ni, adv |=> out_vld_q, "advanced item lost")
  `FA_ASSERT_RST(a_rst, clk_i, !rst_ni |=> !out_vld_q || rst_ni, "valid after reset")
endmodule
`default_nettype wire
